[rtl/core/decimal_radix_sort_macros.svh]
// Assertion macros shared by the decimal radix sort checkers.
`ifndef DECIMAL_RADIX_SORT_MACROS_SVH
`define DECIMAL_RADIX_SORT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/drs_pkg.sv]
// Package with the constants and types of the decimal radix sort block.
`timescale 1ns / 1ps
package drs_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned VAL_W     = 30;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [VAL_W-1:0] VALUE_CAP = VAL_W'(999999999);

  typedef struct packed {
    logic [VAL_W-1:0] key_value;
    logic             last_item;
  } drs_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             final_result;
  } drs_out_t;

  // One value slot of the sorting chain.
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } drs_slot_t;

endpackage

[rtl/core/drs_cell.sv]
// One cell of the insertion sorting chain: keeps the smaller value, passes the larger on; a pop takes the right value.
`timescale 1ns / 1ps
module drs_cell
  import drs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_i,
  input  drs_slot_t ins_i,
  input  drs_slot_t right_i,
  output drs_slot_t held_o,
  output drs_slot_t pass_o
);

  drs_slot_t held_q, held_d;
  drs_slot_t pass_q, pass_d;

  always_comb begin
    held_d = held_q;
    pass_d = '0;
    if (pop_i) begin
      // The whole chain shifts one cell toward the head.
      held_d = right_i;
    end else if (ins_i.vld) begin
      if (!held_q.vld) begin
        held_d = ins_i;
      end else if (ins_i.val < held_q.val) begin
        held_d = ins_i;
        pass_d = held_q;
      end else begin
        pass_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

[rtl/core/decimal_radix_sort.sv]
// Top level of the decimal radix sort block: value store, control and cell chain.
`timescale 1ns / 1ps
// Usage:
// An input item is taken at a clock edge with start_i high and busy_o low. Items
// are stored one per cycle until one carries last_item, or until the store holds
// MAX_ITEMS values; values above 999999999 are stored as 999999999.
// After the set ends busy_o rises and the block works on its own: it feeds the
// stored values into a chain of MAX_ITEMS compare cells, lets the last value
// ripple to its place, and then emits the set.
// Results come in position order, one per cycle, each marked by result_valid_o
// for one cycle; final_result marks the last one. The receiver cannot stall.
// The time a set occupies is set by the chain ripple time and the single read
// port of the value store.
// cfg_we_i writes odd_positions_only; it is sampled when a set ends. In that
// mode only odd positions enter the chain and even positions are read back
// from the store unchanged.
// Reset empties the chain, clears the item count and the mode register; the
// value store needs no clearing since only entries of the current set are read.
module decimal_radix_sort
  import drs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     start_i,
  input  drs_in_t  item_i,
  output logic     busy_o,
  output logic     result_valid_o,
  output drs_out_t result_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FEED,
    ST_SETTLE,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic              odd_cfg_q;
  logic              odd_mode_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] idx_q;
  logic [CNT_W-1:0]  settle_q;
  logic              feed_v_q;
  logic              feed_odd_q;
  logic              out_v_q;
  logic              out_sorted_q;
  logic              out_last_q;
  logic [VAL_W-1:0]  pop_val_q;

  logic [VAL_W-1:0]  mem_q [MAX_ITEMS];
  logic [VAL_W-1:0]  rd_q;

  logic              accept;
  logic              set_end;
  logic [VAL_W-1:0]  sat_val;
  logic              idx_last;
  logic              emit_sorted;
  logic              pop;
  drs_slot_t         feed_slot;
  drs_slot_t         held  [MAX_ITEMS];
  drs_slot_t         link  [MAX_ITEMS];

  assign busy_o  = (state_q != ST_LOAD);
  assign accept  = start_i && !busy_o;
  assign set_end = item_i.last_item || (cnt_q == CNT_W'(MAX_ITEMS - 1));
  assign sat_val = (item_i.key_value > VALUE_CAP) ? VALUE_CAP : item_i.key_value;
  assign idx_last = ({1'b0, idx_q} == CNT_W'(cnt_q - CNT_W'(1)));

  // In odd mode only odd positions come out of the chain.
  assign emit_sorted = !odd_mode_q || idx_q[0];
  assign pop         = (state_q == ST_EMIT) && emit_sorted;

  assign feed_slot.vld = feed_v_q && (!odd_mode_q || feed_odd_q);
  assign feed_slot.val = rd_q;

  // Value store: one write port while loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[cnt_q[ADDR_W-1:0]] <= sat_val;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      odd_cfg_q    <= 1'b0;
      odd_mode_q   <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      settle_q     <= '0;
      feed_v_q     <= 1'b0;
      feed_odd_q   <= 1'b0;
      out_v_q      <= 1'b0;
      out_sorted_q <= 1'b0;
      out_last_q   <= 1'b0;
      pop_val_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        odd_cfg_q <= cfg_wdata_i;
      end
      feed_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
            if (set_end) begin
              odd_mode_q <= odd_cfg_q;
              idx_q      <= '0;
              state_q    <= ST_FEED;
            end
          end
        end
        ST_FEED: begin
          feed_v_q   <= 1'b1;
          feed_odd_q <= idx_q[0];
          idx_q      <= ADDR_W'(idx_q + ADDR_W'(1));
          if (idx_last) begin
            idx_q    <= '0;
            settle_q <= '0;
            state_q  <= ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          settle_q <= CNT_W'(settle_q + CNT_W'(1));
          if (settle_q == CNT_W'(MAX_ITEMS)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          out_v_q      <= 1'b1;
          out_sorted_q <= emit_sorted;
          out_last_q   <= idx_last;
          pop_val_q    <= held[0].val;
          idx_q        <= ADDR_W'(idx_q + ADDR_W'(1));
          if (idx_last) begin
            idx_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign link[0] = feed_slot;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == MAX_ITEMS - 1) begin : g_tail
      drs_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .pop_i   (pop),
        .ins_i   (link[i]),
        .right_i ('0),
        .held_o  (held[i]),
        .pass_o  ()
      );
    end else begin : g_body
      drs_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .pop_i   (pop),
        .ins_i   (link[i]),
        .right_i (held[i+1]),
        .held_o  (held[i]),
        .pass_o  (link[i+1])
      );
    end
  end

  assign result_valid_o        = out_v_q;
  assign result_o.sorted_value = out_sorted_q ? pop_val_q : rd_q;
  assign result_o.final_result = out_last_q;

endmodule

[rtl/core/drs_checker.sv]
// Port-level checker for the decimal radix sort block, bound to the top level.
`timescale 1ns / 1ps
`include "decimal_radix_sort_macros.svh"
module drs_checker
  import drs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input drs_in_t  item_i,
  input logic     busy_o,
  input logic     result_valid_o,
  input drs_out_t result_o
);

  // A set that ends with last_item must hold the block busy on the next cycle.
  `DRS_ASSERT(a_last_sets_busy, start_i && !busy_o && item_i.last_item |=> busy_o, "set end did not raise busy")

  // Results other than the final one appear only while the block is busy.
  `DRS_ASSERT(a_mid_result_busy, result_valid_o && !result_o.final_result |-> busy_o, "result outside a busy period")

  // The final result of a set releases the block for the next set.
  `DRS_ASSERT(a_final_frees, result_valid_o && result_o.final_result |-> !busy_o, "busy after final result")

  // The final mark never shows without a result strobe.
  `DRS_ASSERT_ALWAYS(a_final_strobed, result_o.final_result |-> result_valid_o, "final mark without strobe")

endmodule

bind decimal_radix_sort drs_checker u_drs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .item_i         (item_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

[verif/decimal_radix_sort_tb.sv]
// Self-checking testbench for the decimal radix sort block.
`timescale 1ns / 1ps
module decimal_radix_sort_tb;
  import drs_pkg::*;

  localparam int unsigned SETTLE_CYC = 3 * MAX_ITEMS + 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 100;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic     cfg_wdata_i = 1'b0;
  logic     start_i     = 1'b0;
  drs_in_t  item_i      = '0;
  logic     busy_o;
  logic     result_valid_o;
  drs_out_t result_o;

  drs_in_t          pend_q[$];
  drs_out_t         sorted_q[$];
  logic [VAL_W-1:0] open_set[$];
  bit               odd_mode;
  int unsigned      sender_idle_pct;
  int unsigned      err_count;
  int unsigned      cyc_count;
  drs_out_t         want;

  decimal_radix_sort uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .item_i        (item_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic note_mismatch(input string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Stores one accepted value; at the end of a set the sorted set is queued.
  task automatic absorb_item(input drs_in_t it);
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] tmp;
    drs_out_t         r;
    int               n;
    int               first;
    int               stride;
    int               i;
    int               j;
    v = (it.key_value > VALUE_CAP) ? VALUE_CAP : it.key_value;
    open_set.push_back(v);
    if (it.last_item || open_set.size() == MAX_ITEMS) begin
      n = open_set.size();
      first = odd_mode ? 1 : 0;
      stride = odd_mode ? 2 : 1;
      // Insertion sort over the selected positions; other positions stay put.
      for (i = first + stride; i < n; i += stride) begin
        tmp = open_set[i];
        j = i - stride;
        while (j >= first && open_set[j] > tmp) begin
          open_set[j + stride] = open_set[j];
          j -= stride;
        end
        open_set[j + stride] = tmp;
      end
      for (i = 0; i < n; i++) begin
        r.sorted_value = open_set[i];
        r.final_result = (i == n - 1);
        sorted_q.push_back(r);
      end
      open_set.delete();
    end
  endtask

  task automatic add_item(input logic [VAL_W-1:0] key, input logic last);
    drs_in_t it;
    it.key_value = key;
    it.last_item = last;
    pend_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || start_i || sorted_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
  endtask

  // Item driver: holds an item until the block takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start_i <= 1'b1;
        item_i  <= pend_q.pop_front();
      end else begin
        start_i <= 1'b0;
        item_i  <= drs_in_t'($urandom);
      end
    end
  end

  // Monitor: tracks the mode register, predicts and checks results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) odd_mode = cfg_wdata_i;
      if (result_valid_o) begin
        if (sorted_q.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing expected",
                                  result_o.sorted_value));
        end else begin
          want = sorted_q.pop_front();
          if (result_o.sorted_value !== want.sorted_value)
            note_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    result_o.sorted_value, want.sorted_value));
          if (result_o.final_result !== want.final_result)
            note_mismatch($sformatf("final_result %b, expected %b",
                                    result_o.final_result, want.final_result));
        end
      end
      if (start_i && !busy_o) absorb_item(item_i);
    end
  end

  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit          phase_mode[4];
    int unsigned phase_idle[4];
    int unsigned phase_items;
    int unsigned set_size;
    int unsigned k;
    int          ph;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] prev_key;
    phase_mode = '{1'b0, 1'b1, 1'b1, 1'b0};
    phase_idle = '{0, 58, 0, 33};
    sender_idle_pct = 0;
    odd_mode = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b0);
    add_item(30'd0, 1'b1);
    add_item(30'd999999999, 1'b1);
    // Saturation, duplicates and digit extremes in one set.
    add_item(30'h3FFFFFFF, 1'b0);
    add_item(30'd1000000000, 1'b0);
    add_item(30'd5, 1'b0);
    add_item(30'd999999999, 1'b0);
    add_item(30'd0, 1'b0);
    add_item(30'd10, 1'b0);
    add_item(30'd100000000, 1'b0);
    add_item(30'd5, 1'b1);
    wait_drained();
    write_mode(1'b1);
    // In odd mode a single item and a pair have nothing to reorder.
    add_item(30'd7, 1'b1);
    add_item(30'd9, 1'b0);
    add_item(30'd3, 1'b1);
    add_item(30'd50, 1'b0);
    add_item(30'd40, 1'b0);
    add_item(30'd30, 1'b0);
    add_item(30'd20, 1'b0);
    add_item(30'd10, 1'b0);
    add_item(30'h3FFFFFFF, 1'b0);
    add_item(30'd0, 1'b1);
    // The mode is taken when the set ends, so this set sorts fully.
    add_item(30'd8, 1'b0);
    add_item(30'd6, 1'b0);
    add_item(30'd4, 1'b0);
    wait_drained();
    write_mode(1'b0);
    add_item(30'd2, 1'b1);

    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_mode(phase_mode[ph]);
      sender_idle_pct = phase_idle[ph];
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0:       set_size = MAX_ITEMS;
          1, 2:    set_size = $urandom_range(13, MAX_ITEMS - 1);
          default: set_size = $urandom_range(1, 12);
        endcase
        prev_key = '0;
        for (k = 0; k < set_size; k++) begin
          case ($urandom_range(0, 9))
            0:       key = VAL_W'($urandom_range(0, 9));
            1:       key = VAL_W'($urandom_range(0, 99));
            5:       key = VAL_W'($urandom_range(1000000000, 30'h3FFFFFFF));
            6:       key = VALUE_CAP;
            7:       key = VAL_W'($urandom);
            8:       key = VAL_W'($urandom_range(0, 9) * (10 ** $urandom_range(0, 8)));
            9:       key = prev_key;
            default: key = VAL_W'($urandom_range(0, 999999999));
          endcase
          prev_key = key;
          // A full store ends the set whatever the last flag says.
          if (k == set_size - 1)
            add_item(key, (set_size == MAX_ITEMS) ? 1'($urandom) : 1'b1);
          else
            add_item(key, 1'b0);
        end
        phase_items += set_size;
      end
    end

    while (pend_q.size() != 0 || start_i) @(posedge clk_i);
    k = 0;
    while (sorted_q.size() != 0 && k < 4 * SETTLE_CYC) begin
      @(posedge clk_i);
      k++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sorted_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", sorted_q.size()));
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
